>>> src/mba_pkg.sv
// mba_pkg: shared constants and types for the multichannel block averager.
// Used by mba_ctrl, mba_datapath, mba_checker and the top level.
package mba_pkg;

  localparam int NUM_CH   = 6;
  localparam int NUM_BINS = 10;
  localparam int SAMPLE_W = 16;
  localparam int RPB_W    = 12;
  localparam int MAX_RPB  = 4095;
  localparam int BIN_W    = 4;
  localparam int SUM_W    = 28;
  localparam int MAG_W    = SUM_W - 1;
  localparam int CH_W     = 3;
  localparam int STEP_W   = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [RPB_W-1:0]           rpb_t;
  typedef logic [BIN_W-1:0]           bin_t;
  typedef logic [CH_W-1:0]            ch_t;

  // controller -> datapath
  typedef struct packed {
    logic acc;        // add the row into the channel sums
    logic acc_clr;    // start sums from zero (frame start)
    logic clr_sums;   // bin closed, clear sums
    logic div_load;   // load |sum[ch]| into the divider
    logic div_step;   // one radix-2 step
    logic div_store;  // write signed quotient of ch to staging
    ch_t  ch;
    rpb_t divisor;
    logic out_load;   // move staging into the output word
    bin_t bin;
    logic last;
  } mba_cmd_t;

endpackage

>>> src/mba_ctrl.sv
// mba_ctrl: controller FSM, row/bin counters, frame state, config register.
// Depends on mba_pkg; drives mba_datapath through mba_cmd_t.
module mba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  mba_pkg::rpb_t     cfg_rows_per_bin,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_frame_start,
  output logic              out_valid,
  input  logic              out_ready,
  output mba_pkg::mba_cmd_t cmd
);
  import mba_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_STEP  = 5'b00100,
    ST_STORE = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  rpb_t   rpb_r, rpb_nxt;
  rpb_t   rows_r, rows_nxt;
  bin_t   bin_r, bin_nxt;
  bin_t   obin_r, obin_nxt;
  logic   olast_r, olast_nxt;
  logic   done_r, done_nxt;
  logic   out_valid_r, out_valid_nxt;
  ch_t    ch_r, ch_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  rpb_t rpb_eff;
  rpb_t rows_inc;
  bin_t bin_base;
  logic active;
  logic close;

  always_comb begin
    if (rpb_r == '0) begin
      rpb_eff = RPB_W'(1);
    end else if (rpb_r > RPB_W'(MAX_RPB)) begin
      rpb_eff = RPB_W'(MAX_RPB);
    end else begin
      rpb_eff = rpb_r;
    end
    rows_inc = (in_frame_start ? '0 : rows_r) + RPB_W'(1);
    bin_base = in_frame_start ? '0 : bin_r;
    active   = in_frame_start || !done_r;
    close    = rows_inc >= rpb_eff;
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    rpb_nxt       = (cfg_valid && cfg_ready) ? cfg_rows_per_bin : rpb_r;
    rows_nxt      = rows_r;
    bin_nxt       = bin_r;
    obin_nxt      = obin_r;
    olast_nxt     = olast_r;
    done_nxt      = done_r;
    ch_nxt        = ch_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;

    cmd           = '0;
    cmd.ch        = ch_r;
    cmd.divisor   = rpb_eff;
    cmd.bin       = obin_r;
    cmd.last      = olast_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && active) begin
          cmd.acc     = 1'b1;
          cmd.acc_clr = in_frame_start;
          if (in_frame_start) begin
            bin_nxt  = '0;
            done_nxt = 1'b0;
          end
          if (close) begin
            rows_nxt  = '0;
            obin_nxt  = bin_base;
            olast_nxt = (bin_base == BIN_W'(NUM_BINS - 1));
            if (bin_base >= BIN_W'(NUM_BINS - 1)) begin
              bin_nxt  = '0;
              done_nxt = 1'b1;
            end else begin
              bin_nxt = bin_base + BIN_W'(1);
            end
            ch_nxt    = '0;
            state_nxt = ST_LOAD;
          end else begin
            rows_nxt = rows_inc;
          end
        end
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_STEP;
      end
      ST_STEP: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(MAG_W - 1)) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.div_store = 1'b1;
        if (ch_r == CH_W'(NUM_CH - 1)) begin
          cmd.clr_sums = 1'b1;
          state_nxt    = ST_OUT;
        end else begin
          ch_nxt    = ch_r + CH_W'(1);
          state_nxt = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rpb_r       <= RPB_W'(1);
      rows_r      <= '0;
      bin_r       <= '0;
      done_r      <= 1'b1;
      out_valid_r <= 1'b0;
      ch_r        <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      rpb_r       <= rpb_nxt;
      rows_r      <= rows_nxt;
      bin_r       <= bin_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      ch_r        <= ch_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obin_r  <= obin_nxt;
    olast_r <= olast_nxt;
  end

endmodule

>>> src/mba_datapath.sv
// mba_datapath: channel sums, shared radix-2 divider, staging and output word.
// Depends on mba_pkg; commanded by mba_ctrl.
module mba_datapath (
  input  logic              clk,
  input  mba_pkg::mba_cmd_t cmd,
  input  mba_pkg::sample_t  sample   [mba_pkg::NUM_CH],
  output mba_pkg::bin_t     out_bin,
  output logic              out_last,
  output mba_pkg::sample_t  out_avg  [mba_pkg::NUM_CH]
);
  import mba_pkg::*;

  sum_t    sum_r   [NUM_CH];
  sample_t avg_r   [NUM_CH];
  sample_t oavg_r  [NUM_CH];
  bin_t    obin_r;
  logic    olast_r;

  logic [MAG_W-1:0] num_r;
  rpb_t             rem_r;
  rpb_t             div_r;
  logic             neg_r;

  sum_t             cur_sum;
  sum_t             neg_sum;
  logic [RPB_W:0]   trial;
  logic [RPB_W:0]   diff;
  logic             ge;
  logic [SAMPLE_W-1:0] q_lo;

  always_comb begin
    cur_sum = sum_r[cmd.ch];
    neg_sum = -cur_sum;
    trial   = {rem_r, num_r[MAG_W-1]};
    diff    = trial - {1'b0, div_r};
    ge      = trial >= {1'b0, div_r};
    q_lo    = num_r[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (cmd.clr_sums) begin
        sum_r[c] <= '0;
      end else if (cmd.acc) begin
        sum_r[c] <= (cmd.acc_clr ? '0 : sum_r[c]) + sum_t'(sample[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg_r <= cur_sum[SUM_W-1];
      num_r <= cur_sum[SUM_W-1] ? neg_sum[MAG_W-1:0] : cur_sum[MAG_W-1:0];
      rem_r <= '0;
      div_r <= cmd.divisor;
    end else if (cmd.div_step) begin
      num_r <= {num_r[MAG_W-2:0], ge};
      rem_r <= ge ? diff[RPB_W-1:0] : trial[RPB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      avg_r[cmd.ch] <= neg_r ? sample_t'(SAMPLE_W'(0) - q_lo) : sample_t'(q_lo);
    end
    if (cmd.out_load) begin
      oavg_r  <= avg_r;
      obin_r  <= cmd.bin;
      olast_r <= cmd.last;
    end
  end

  assign out_avg  = oavg_r;
  assign out_bin  = obin_r;
  assign out_last = olast_r;

endmodule

>>> src/multichannel_block_averager_unit.sv
// Multichannel block averager (boxcar decimating average), top level.
// Instantiates mba_ctrl and mba_datapath; depends on mba_pkg.
//
// Each input word is one row of six signed 16-bit samples that is added into
// per-channel 28-bit sums. A row that does not close a bin leaves the FSM in
// ST_IDLE, so such rows may arrive back to back. The row that fills a bin
// starts a shared radix-2 divider that serves the six channels in turn
// (load, 27 quotient steps, store), and in_ready stays low from that row until
// the result word is loaded, which waits while the previous result word is
// still held on the output. Rows after the tenth bin are dropped until a
// frame-start row. There is no clearing pass after reset.
module multichannel_block_averager_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  mba_pkg::rpb_t    cfg_rows_per_bin,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_frame_start,
  input  mba_pkg::sample_t in_sample_ch0,
  input  mba_pkg::sample_t in_sample_ch1,
  input  mba_pkg::sample_t in_sample_ch2,
  input  mba_pkg::sample_t in_sample_ch3,
  input  mba_pkg::sample_t in_sample_ch4,
  input  mba_pkg::sample_t in_sample_ch5,
  output logic             out_valid,
  input  logic             out_ready,
  output mba_pkg::bin_t    out_bin_index,
  output logic             out_last_bin,
  output mba_pkg::sample_t out_average_ch0,
  output mba_pkg::sample_t out_average_ch1,
  output mba_pkg::sample_t out_average_ch2,
  output mba_pkg::sample_t out_average_ch3,
  output mba_pkg::sample_t out_average_ch4,
  output mba_pkg::sample_t out_average_ch5
);
  import mba_pkg::*;

  mba_cmd_t cmd;
  sample_t  sample [NUM_CH];
  sample_t  avg    [NUM_CH];

  assign sample[0] = in_sample_ch0;
  assign sample[1] = in_sample_ch1;
  assign sample[2] = in_sample_ch2;
  assign sample[3] = in_sample_ch3;
  assign sample[4] = in_sample_ch4;
  assign sample[5] = in_sample_ch5;

  assign out_average_ch0 = avg[0];
  assign out_average_ch1 = avg[1];
  assign out_average_ch2 = avg[2];
  assign out_average_ch3 = avg[3];
  assign out_average_ch4 = avg[4];
  assign out_average_ch5 = avg[5];

  mba_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_rows_per_bin (cfg_rows_per_bin),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .cmd              (cmd)
  );

  mba_datapath u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .sample   (sample),
    .out_bin  (out_bin_index),
    .out_last (out_last_bin),
    .out_avg  (avg)
  );

endmodule

>>> src/mba_checker.sv
// mba_checker: port-level assertions for the block averager, bound to the top.
// Depends on mba_pkg and multichannel_block_averager_unit.
module mba_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input mba_pkg::bin_t out_bin_index,
  input logic          out_last_bin
);
  import mba_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_bin_index) && $stable(out_last_bin))
    else $error("output word changed while stalled");

  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bin_index <= BIN_W'(NUM_BINS - 1))
    else $error("bin index out of range");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_bin == (out_bin_index == BIN_W'(NUM_BINS - 1))))
    else $error("last-bin flag does not match bin index");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("output word dropped without handshake");

endmodule

bind multichannel_block_averager_unit mba_checker u_mba_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_bin_index (out_bin_index),
  .out_last_bin  (out_last_bin)
);
